// ----- design/xeu_pkg.sv -----
// package: types, entity tables and the per-unit decode function of the entity unescaper
`default_nettype none

package xeu_pkg;

	localparam int UnitW      = 16;
	localparam int MaxResults = 6;
	localparam int CountW     = $clog2(MaxResults + 1);

	typedef logic [3:0] match_t;

	localparam match_t ST_IDLE = 4'd0;
	localparam match_t ST_AMP  = 4'd1;
	localparam match_t ST_LAST = 4'd12;

	localparam logic [UnitW-1:0] AMP = 16'h0026;

	localparam logic [UnitW-1:0] ENT_BODY [4][5] = '{
		'{16'h0061, 16'h006D, 16'h0070, 16'h003B, 16'h0000},
		'{16'h006C, 16'h0074, 16'h003B, 16'h0000, 16'h0000},
		'{16'h0067, 16'h0074, 16'h003B, 16'h0000, 16'h0000},
		'{16'h0071, 16'h0075, 16'h006F, 16'h0074, 16'h003B}
	};
	localparam logic [2:0]       ENT_LEN  [4] = '{3'd4, 3'd3, 3'd3, 3'd5};
	localparam logic [UnitW-1:0] ENT_CHAR [4] = '{16'h0026, 16'h003C, 16'h003E, 16'h0022};
	localparam match_t           ENT_BASE [4] = '{4'd2, 4'd5, 4'd7, 4'd9};

	localparam logic [1:0] ST_ENT [13] = '{
		2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3
	};
	localparam logic [2:0] ST_LEN [13] = '{
		3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3, 3'd4
	};

	typedef struct packed {
		logic [MaxResults-1:0][UnitW-1:0] units;
		logic [CountW-1:0]                count;
		match_t                           next;
	} step_t;

	function automatic step_t append_unit(input step_t r, input logic [UnitW-1:0] u);
		step_t o;
		o = r;
		if (r.count < CountW'(MaxResults)) begin
			o.units[r.count] = u;
			o.count = r.count + CountW'(1);
		end
		return o;
	endfunction

	// emits "&" followed by the entity characters matched so far
	function automatic step_t append_prefix(input step_t r, input match_t s);
		step_t      o;
		logic [1:0] e;
		logic [2:0] k;
		e = ST_ENT[s];
		k = ST_LEN[s];
		o = append_unit(r, AMP);
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < k) begin
				o = append_unit(o, ENT_BODY[e][i]);
			end
		end
		return o;
	endfunction

	function automatic step_t unescape_step(input match_t st, input logic [UnitW-1:0] cu,
			input logic eot);
		step_t      r;
		match_t     s;
		logic       mis;
		logic [1:0] e;
		logic [2:0] k;
		r.units = '0;
		r.count = '0;
		r.next  = ST_IDLE;
		s   = (st > ST_LAST) ? ST_IDLE : st;
		mis = 1'b0;
		e   = ST_ENT[s];
		k   = ST_LEN[s];
		if (s == ST_IDLE) begin
			if (cu == AMP) begin
				s = ST_AMP;
			end else begin
				r = append_unit(r, cu);
			end
		end else if (s == ST_AMP) begin
			mis = 1'b1;
			for (int i = 0; i < 4; i++) begin
				if (mis && cu == ENT_BODY[i][0]) begin
					s   = ENT_BASE[i];
					mis = 1'b0;
				end
			end
		end else begin
			if (cu == ENT_BODY[e][k]) begin
				if (3'(k + 3'd1) == ENT_LEN[e]) begin
					r = append_unit(r, ENT_CHAR[e]);
					s = ST_IDLE;
				end else begin
					s = s + 4'd1;
				end
			end else begin
				mis = 1'b1;
			end
		end
		if (mis) begin
			r = append_prefix(r, s);
			if (cu == AMP) begin
				s = ST_AMP;
			end else begin
				r = append_unit(r, cu);
				s = ST_IDLE;
			end
		end
		if (eot && s != ST_IDLE) begin
			r = append_prefix(r, s);
			s = ST_IDLE;
		end
		r.next = s;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/xml_entity_unescape_unit.sv -----
// top level: streaming unescaper for &amp; &lt; &gt; &quot; on 16-bit code units
`default_nettype none

// Takes one UTF-16 code unit per transaction and returns the unescaped text, one code unit
// per output transaction. A code unit is registered, decoded against the pending entity
// prefix and its results (zero to six) are loaded into a result buffer that drains through
// the single output port at one unit per cycle while out_stall is low. The sustained rate is
// one code unit per cycle while each unit gives at most one result and the output is not
// stalled; a unit that gives more results holds back the next unit until its last is taken.
// last_of_run marks the final result of a code unit, text_done the final result of a string
// ended with end_of_text, where any pending prefix is flushed unchanged.
module xml_entity_unescape_unit
	import xeu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [UnitW-1:0] code_unit,
	input  wire logic             end_of_text,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [UnitW-1:0]      out_unit,
	output logic                  last_of_run,
	output logic                  text_done
);

	logic                             in_valid_s1;
	logic [UnitW-1:0]                 code_unit_s1;
	logic                             end_of_text_s1;
	match_t                           match_state_q;
	logic [MaxResults-1:0][UnitW-1:0] res_unit_s2;
	logic [CountW-1:0]                res_cnt_s2;
	logic                             res_end_s2;
	step_t                            step;
	logic                             in_take;
	logic                             out_take;
	logic                             consume;

	assign step     = unescape_step(match_state_q, code_unit_s1, end_of_text_s1);
	assign out_take = out_valid && !out_stall;
	assign consume  = in_valid_s1 &&
		(res_cnt_s2 == '0 || (res_cnt_s2 == CountW'(1) && out_take));
	assign in_stall = in_valid_s1 && !consume;
	assign in_take  = in_valid && !in_stall;

	assign out_valid   = res_cnt_s2 != '0;
	assign out_unit    = res_unit_s2[0];
	assign last_of_run = res_cnt_s2 == CountW'(1);
	assign text_done   = last_of_run && res_end_s2;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1   <= 1'b0;
			match_state_q <= ST_IDLE;
			res_cnt_s2    <= '0;
		end else begin
			if (in_take) begin
				in_valid_s1 <= 1'b1;
			end else if (consume) begin
				in_valid_s1 <= 1'b0;
			end
			if (consume) begin
				match_state_q <= step.next;
				res_cnt_s2    <= step.count;
			end else if (out_take) begin
				res_cnt_s2 <= res_cnt_s2 - CountW'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			code_unit_s1   <= code_unit;
			end_of_text_s1 <= end_of_text;
		end
		if (consume) begin
			res_unit_s2 <= step.units;
			res_end_s2  <= end_of_text_s1;
		end else if (out_take) begin
			res_unit_s2 <= {UnitW'(0), res_unit_s2[MaxResults-1:1]};
		end
	end

endmodule

`default_nettype wire

// ----- design/xeu_checker.sv -----
// checker: port-level assertions for the entity unescaper, bound to the top level
`default_nettype none

module xeu_checker
	import xeu_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [UnitW-1:0] out_unit,
	input wire logic             last_of_run,
	input wire logic             text_done
);

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_unit) &&
			$stable(last_of_run) && $stable(text_done))
		else $error("stalled output transaction changed");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> last_of_run)
		else $error("text_done without last_of_run");

	// more results of the same code unit follow at once
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("run of results broken");

	// input only backs up behind pending results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

endmodule

bind xml_entity_unescape_unit xeu_checker u_xeu_checker (.*);

`default_nettype wire

// ----- sim/xml_entity_unescape_unit_tb.sv -----
// testbench: random and directed entity text through the unescaper, checked against a scoreboard
`timescale 1ns / 1ps

module xml_entity_unescape_unit_tb;
	import xeu_pkg::UnitW;

	localparam logic [UnitW-1:0] CH_AMP  = 16'h0026;
	localparam logic [UnitW-1:0] CH_SEMI = 16'h003B;
	localparam logic [UnitW-1:0] CH_LT   = 16'h003C;
	localparam logic [UnitW-1:0] CH_GT   = 16'h003E;
	localparam logic [UnitW-1:0] CH_QUOT = 16'h0022;
	localparam logic [UnitW-1:0] CH_A    = 16'h0061;
	localparam logic [UnitW-1:0] CH_M    = 16'h006D;
	localparam logic [UnitW-1:0] CH_P    = 16'h0070;
	localparam logic [UnitW-1:0] CH_L    = 16'h006C;
	localparam logic [UnitW-1:0] CH_T    = 16'h0074;
	localparam logic [UnitW-1:0] CH_G    = 16'h0067;
	localparam logic [UnitW-1:0] CH_Q    = 16'h0071;
	localparam logic [UnitW-1:0] CH_U    = 16'h0075;
	localparam logic [UnitW-1:0] CH_O    = 16'h006F;

	localparam int NumEntities = 4;
	localparam int HoldCycles  = 80;
	localparam int DrainCycles = 10;

	localparam logic [UnitW-1:0] ENTITY_TEXT [NumEntities][6] = '{
		'{CH_AMP, CH_A, CH_M, CH_P, CH_SEMI, '0},
		'{CH_AMP, CH_L, CH_T, CH_SEMI, '0, '0},
		'{CH_AMP, CH_G, CH_T, CH_SEMI, '0, '0},
		'{CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI}
	};
	localparam int               ENTITY_LEN  [NumEntities] = '{5, 4, 4, 6};
	localparam logic [UnitW-1:0] ENTITY_CHAR [NumEntities] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT};

	typedef struct {
		logic [UnitW-1:0] unit;
		logic             run_end;
		logic             text_end;
	} text_unit_t;

	class unescape_scoreboard;
		text_unit_t       unescaped_q[$];
		logic [UnitW-1:0] held_prefix[$];
		int               errors;

		function new();
			errors = 0;
		endfunction

		// index of the entity that seq is a prefix of, or -1
		function int entity_match(input logic [UnitW-1:0] seq[$], output bit full);
			bit ok;
			full = 1'b0;
			for (int e = 0; e < NumEntities; e++) begin
				if (seq.size() <= ENTITY_LEN[e]) begin
					ok = 1'b1;
					for (int i = 0; i < seq.size(); i++) begin
						if (seq[i] != ENTITY_TEXT[e][i]) ok = 1'b0;
					end
					if (ok) begin
						full = (seq.size() == ENTITY_LEN[e]);
						return e;
					end
				end
			end
			return -1;
		endfunction

		function void note_code_unit(input logic [UnitW-1:0] cu, input logic eot);
			logic [UnitW-1:0] cand[$];
			logic [UnitW-1:0] run[$];
			text_unit_t       t;
			int               e;
			bit               full;
			if (held_prefix.size() == 0) begin
				if (cu == CH_AMP) held_prefix.push_back(cu);
				else run.push_back(cu);
			end else begin
				cand = held_prefix;
				cand.push_back(cu);
				e = entity_match(cand, full);
				if (e >= 0 && full) begin
					run.push_back(ENTITY_CHAR[e]);
					held_prefix.delete();
				end else if (e >= 0) begin
					held_prefix = cand;
				end else begin
					// prefix goes out unchanged, the unit is handled afresh
					foreach (held_prefix[i]) run.push_back(held_prefix[i]);
					held_prefix.delete();
					if (cu == CH_AMP) held_prefix.push_back(cu);
					else run.push_back(cu);
				end
			end
			if (eot) begin
				foreach (held_prefix[i]) run.push_back(held_prefix[i]);
				held_prefix.delete();
			end
			foreach (run[i]) begin
				t.unit     = run[i];
				t.run_end  = (i == run.size() - 1);
				t.text_end = (i == run.size() - 1) && eot;
				unescaped_q.push_back(t);
			end
		endfunction

		task report_mismatch(input string what, input logic [UnitW-1:0] want,
				input logic [UnitW-1:0] got);
			$display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
			errors++;
		endtask

		task check_unit(input logic [UnitW-1:0] u, input logic lr, input logic td);
			text_unit_t t;
			if (unescaped_q.size() == 0) begin
				report_mismatch("result with nothing due", '0, u);
			end else begin
				t = unescaped_q.pop_front();
				if (u !== t.unit) report_mismatch("out_unit", t.unit, u);
				if (lr !== t.run_end) report_mismatch("last_of_run", UnitW'(t.run_end), UnitW'(lr));
				if (td !== t.text_end) report_mismatch("text_done", UnitW'(t.text_end), UnitW'(td));
			end
		endtask

		function int results_due();
			return unescaped_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [UnitW-1:0] code_unit;
	logic             end_of_text;
	logic             out_valid;
	logic             out_stall;
	logic [UnitW-1:0] out_unit;
	logic             last_of_run;
	logic             text_done;

	unescape_scoreboard sb;
	logic [UnitW-1:0]   text_buf[$];
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 items_sent;
	int                 hold_pending;
	int                 hold_served;

	xml_entity_unescape_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_unit    (out_unit),
		.last_of_run (last_of_run),
		.text_done   (text_done)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_code_unit(code_unit, end_of_text);
			if (out_valid && !out_stall) sb.check_unit(out_unit, last_of_run, text_done);
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int held;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending != hold_served) begin
				held = 0;
				while (held < HoldCycles) begin
					out_stall <= 1'b1;
					held++;
					@(posedge clk);
				end
				hold_served = hold_pending;
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		#1_000_000;
		$display("** xml_entity_unescape_unit: FAILED **");
		$finish;
	end

	task automatic send_unit(input logic [UnitW-1:0] cu, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		code_unit   <= cu;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input bit close, input bit noisy);
		logic eot;
		for (int i = 0; i < text_buf.size(); i++) begin
			eot = (close && i == text_buf.size() - 1) || (noisy && $urandom_range(99) < 3);
			send_unit(text_buf[i], eot);
		end
		text_buf.delete();
	endtask

	// the last accepted transaction reaches the scoreboard at that same edge
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.results_due() != 0) @(posedge clk);
	endtask

	function automatic void add_segment();
		int                 kind;
		int                 e;
		int                 n;
		logic [UnitW-1:0]   good;
		kind = $urandom_range(9);
		e    = $urandom_range(NumEntities - 1);
		case (kind)
			0, 1, 2, 3: begin
				for (int i = 0; i < ENTITY_LEN[e]; i++) text_buf.push_back(ENTITY_TEXT[e][i]);
			end
			4, 5: begin
				// entity cut short by a near miss, an ampersand or anything
				n = $urandom_range(1, ENTITY_LEN[e] - 1);
				for (int i = 0; i < n; i++) text_buf.push_back(ENTITY_TEXT[e][i]);
				good = ENTITY_TEXT[e][n];
				case ($urandom_range(2))
					0: text_buf.push_back(good ^ (UnitW'(1) << $urandom_range(UnitW - 1)));
					1: text_buf.push_back(CH_AMP);
					default: text_buf.push_back(UnitW'($urandom_range(65535)));
				endcase
			end
			6: text_buf.push_back(UnitW'($urandom_range(32, 126)));
			7: text_buf.push_back(UnitW'($urandom_range(65535)));
			8: text_buf.push_back(CH_AMP);
			default: text_buf.push_back(ENTITY_TEXT[e][$urandom_range(1, ENTITY_LEN[e] - 1)]);
		endcase
	endfunction

	task automatic run_phase(input int send_pct, input int recv_pct, input int count,
			input bit with_hold);
		int stop_at;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		stop_at        = items_sent + count;
		if (with_hold) hold_pending++;
		while (items_sent < stop_at) begin
			for (int s = $urandom_range(1, 4); s > 0; s--) add_segment();
			send_text($urandom_range(99) < 80, 1'b1);
		end
		wait_all_results();
	endtask

	initial begin
		sb             = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		items_sent     = 0;
		hold_pending   = 0;
		hold_served    = 0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		code_unit      <= '0;
		end_of_text    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes
		text_buf = '{16'h0000};
		send_text(1'b0, 1'b0);
		text_buf = '{16'hFFFF};
		send_text(1'b1, 1'b0);
		// decoded output is not rescanned
		text_buf = '{CH_AMP, CH_A, CH_M, CH_P, CH_SEMI, CH_L, CH_T, CH_SEMI};
		send_text(1'b1, 1'b0);
		text_buf = '{CH_AMP, CH_G, CH_T, CH_SEMI};
		send_text(1'b0, 1'b0);
		// ampersand breaking a match, then a full quote
		text_buf = '{CH_AMP, CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI};
		send_text(1'b0, 1'b0);
		// prefix &quo broken: five results from one unit
		text_buf = '{CH_AMP, CH_Q, CH_U, CH_O, 16'hFFFF};
		send_text(1'b0, 1'b0);
		// pending prefix flushed at end of text
		text_buf = '{CH_AMP, CH_L};
		send_text(1'b1, 1'b0);
		wait_all_results();

		run_phase(33, 77, 85, 1'b0);
		run_phase(77, 33, 85, 1'b0);
		run_phase(0, 0, 85, 1'b1);

		wait_all_results();
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0 && sb.results_due() == 0) begin
			$display("** xml_entity_unescape_unit: PASSED **");
		end else begin
			$display("** xml_entity_unescape_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/xeu_pkg.sv
design/xml_entity_unescape_unit.sv
design/xeu_checker.sv
sim/xml_entity_unescape_unit_tb.sv
